>>> design/pulse_period_speed_meter_unit_defines.svh
// Assertion macros shared by the speed meter RTL.
// Included by modules that check their own control logic; needs clk and arst_n in scope.
`ifndef PULSE_PERIOD_SPEED_METER_UNIT_DEFINES_SVH
`define PULSE_PERIOD_SPEED_METER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PPSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/ppsm_pkg.sv
// Shared types and constants for the pulse period speed meter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ppsm_pkg;

	localparam int GAP_W   = 10;
	localparam int SUM_W   = 24;
	localparam int SCALE_W = 24;
	localparam int RPM_W   = 21;
	localparam int SPEED_W = 16;
	localparam int ACC_W   = SUM_W + SCALE_W + 1;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam int TICKS_PER_MIN = 60000;

	localparam logic [GAP_W-1:0]   GAP_MAX   = '1;
	localparam logic [RPM_W-1:0]   RPM_MAX   = '1;
	localparam logic [SPEED_W-1:0] SPEED_MAX = '1;

	localparam logic [GAP_W-1:0]   GAP_TIMEOUT_RST  = 10'd1000;
	localparam logic [GAP_W-1:0]   MIN_INTERVAL_RST = 10'd10;
	localparam logic [SCALE_W-1:0] SPEED_SCALE_RST  = 24'd233964;

	typedef enum logic [1:0] {
		REG_GAP_TIMEOUT  = 2'd0,
		REG_MIN_INTERVAL = 2'd1,
		REG_SPEED_SCALE  = 2'd2,
		REG_UNUSED       = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} op_stat_t;

	typedef struct packed {
		logic push;
		logic clear;
	} ring_cmd_t;

endpackage

>>> design/pulse_period_speed_meter_unit.sv
// Top level of the pulse period speed meter: stream ports, APB registers, control FSM.
// Depends on ppsm_pkg, ppsm_div, ppsm_mul, ppsm_ring and the assertion macro header.
//
//   channel  | direction | signals                              | content
//   s_*      | in        | s_tvalid s_tready s_tdata            | one tick, pulse flag
//   m_*      | out       | m_tvalid m_tready m_tdata m_tuser    | speed, timeout flag
//   APB      | in        | psel penable pwrite paddr pwdata     | three registers, 32-bit data
//
// A tick without a result is absorbed in ST_IDLE; a timeout tick passes through ST_OUT to the output register.
// A pulse that yields a speed passes through ST_DIV1, ST_RING, ST_MULG, ST_MUL, ST_DIVG, ST_DIV2 and ST_OUT,
// that is two passes through the bit-serial divider and one through the bit-serial multiplier.
// Reset restores register defaults, empties the ring and waits for a first pulse.
// s_tready is high only between ticks; a waiting result blocks the next one only at its hand-off.
`timescale 1ns / 1ps
`include "pulse_period_speed_meter_unit_defines.svh"

module pulse_period_speed_meter_unit #(
	parameter int AVG_DEPTH     = 5,
	parameter int RPM_FRAC_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [0] pulse, [7:1] zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [15:0]                   m_tdata,   // [15:0] speed_centimph
	output logic [0:0]                    m_tuser,   // [0] timed_out
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ppsm_pkg::ADDR_W-1:0]   paddr,
	input  logic [ppsm_pkg::DATA_W-1:0]   pwdata,
	output logic [ppsm_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import ppsm_pkg::*;

	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int DVD1   = TICKS_PER_MIN << RPM_FRAC_BITS;
	localparam int Q1_W   = $clog2(DVD1 + 1);
	localparam int SH     = 16 + RPM_FRAC_BITS;
	localparam int Y_W    = ACC_W - SH;
	localparam int DIV_W  = (Q1_W > Y_W) ? Q1_W : Y_W;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_DIV1 = 8'b0000_0010,
		ST_RING = 8'b0000_0100,
		ST_MULG = 8'b0000_1000,
		ST_MUL  = 8'b0001_0000,
		ST_DIVG = 8'b0010_0000,
		ST_DIV2 = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [GAP_W-1:0]   gap_timeout_q;
	logic [GAP_W-1:0]   min_interval_q;
	logic [SCALE_W-1:0] speed_scale_q;
	logic [GAP_W-1:0]   gap_q;
	logic               awaiting_q;
	logic [RPM_W-1:0]   rpm_q;
	logic [SPEED_W-1:0] res_speed_q;
	logic               res_to_q;
	logic               m_tvalid_q;
	logic [SPEED_W-1:0] m_speed_q;
	logic               m_to_q;

	logic               in_acc;
	logic               pulse;
	logic [GAP_W-1:0]   elapsed;
	logic               timeout_hit;
	logic               cfg_wr;
	reg_idx_t           cfg_idx;
	logic               out_free;

	logic               div_start;
	logic [DIV_W-1:0]   div_dvd;
	logic [GAP_W-1:0]   div_dsr;
	logic [DIV_W-1:0]   div_quo;
	op_stat_t           div_stat;

	logic               mul_start;
	logic [ACC_W-1:0]   mul_init;
	logic [ACC_W-1:0]   mul_prod;
	op_stat_t           mul_stat;

	ring_cmd_t          ring_cmd;
	logic [SUM_W-1:0]   ring_sum;
	logic [FILL_W-1:0]  ring_fill;

	// Register port
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_timeout_q  <= GAP_TIMEOUT_RST;
			min_interval_q <= MIN_INTERVAL_RST;
			speed_scale_q  <= SPEED_SCALE_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_GAP_TIMEOUT:  gap_timeout_q  <= pwdata[GAP_W-1:0];
				REG_MIN_INTERVAL: min_interval_q <= pwdata[GAP_W-1:0];
				REG_SPEED_SCALE:  speed_scale_q  <= pwdata[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_GAP_TIMEOUT:  prdata = DATA_W'(gap_timeout_q);
			REG_MIN_INTERVAL: prdata = DATA_W'(min_interval_q);
			REG_SPEED_SCALE:  prdata = DATA_W'(speed_scale_q);
			default:          prdata = '0;
		endcase
	end

	// Tick decode
	assign s_tready    = (state_q == ST_IDLE);
	assign in_acc      = s_tvalid & s_tready;
	assign pulse       = s_tdata[0];
	assign elapsed     = (gap_q == GAP_MAX) ? GAP_MAX : gap_q + 1'b1;
	assign timeout_hit = (elapsed >= gap_timeout_q);
	assign out_free    = ~m_tvalid_q | m_tready;

	// Datapath steering
	always_comb begin
		div_start      = 1'b0;
		div_dvd        = DIV_W'(DVD1);
		div_dsr        = elapsed;
		mul_start      = (state_q == ST_MULG);
		ring_cmd.push  = (state_q == ST_RING);
		ring_cmd.clear = in_acc & ~pulse & timeout_hit;
		if (in_acc && pulse && !awaiting_q && elapsed > min_interval_q) begin
			div_start = 1'b1;
		end
		if (state_q == ST_DIVG) begin
			div_start = 1'b1;
			div_dvd   = DIV_W'(mul_prod[ACC_W-1:SH]);
			div_dsr   = GAP_W'(ring_fill);
		end
	end

	// Preload half the divisor scale so the final quotient rounds half up.
	assign mul_init = ACC_W'(ring_fill) << (SH - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			gap_q      <= '0;
			awaiting_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (pulse) begin
							gap_q      <= '0;
							awaiting_q <= 1'b0;
							if (div_start) begin
								state_q <= ST_DIV1;
							end
						end else if (timeout_hit) begin
							gap_q      <= '0;
							awaiting_q <= 1'b1;
							state_q    <= ST_OUT;
						end else begin
							gap_q <= elapsed;
						end
					end
				end
				ST_DIV1: if (div_stat.done) begin
					state_q <= ST_RING;
				end
				ST_RING: state_q <= ST_MULG;
				ST_MULG: state_q <= ST_MUL;
				ST_MUL: if (mul_stat.done) begin
					state_q <= ST_DIVG;
				end
				ST_DIVG: state_q <= ST_DIV2;
				ST_DIV2: if (div_stat.done) begin
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_free) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result holding: saturate each quotient as it arrives.
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV1 && div_stat.done) begin
			rpm_q <= (div_quo > DIV_W'(RPM_MAX)) ? RPM_MAX : div_quo[RPM_W-1:0];
		end
		if (state_q == ST_DIV2 && div_stat.done) begin
			res_speed_q <= (div_quo > DIV_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[SPEED_W-1:0];
			res_to_q    <= 1'b0;
		end else if (in_acc && ring_cmd.clear) begin
			res_speed_q <= '0;
			res_to_q    <= 1'b1;
		end
	end

	// Output register: hold until the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			m_speed_q <= res_speed_q;
			m_to_q    <= res_to_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_speed_q;
	assign m_tuser[0] = m_to_q;

	ppsm_div #(
		.DVD_W(DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dvd),
		.divisor (div_dsr),
		.quotient(div_quo),
		.stat    (div_stat)
	);

	ppsm_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (ring_sum),
		.mplier  (speed_scale_q),
		.acc_init(mul_init),
		.product (mul_prod),
		.stat    (mul_stat)
	);

	ppsm_ring #(
		.AVG_DEPTH(AVG_DEPTH)
	) u_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (ring_cmd),
		.rpm   (rpm_q),
		.sum   (ring_sum),
		.fill  (ring_fill)
	);

	`PPSM_ASSERT_NEXT(a_first_pulse_silent, in_acc && pulse && awaiting_q, !awaiting_q && state_q == ST_IDLE, "first pulse must only start timing")
	`PPSM_ASSERT_NEXT(a_timeout_clears, in_acc && !pulse && timeout_hit, state_q == ST_OUT && ring_fill == '0 && res_to_q, "timeout must clear ring and flag result")
	`PPSM_ASSERT_IMP(a_fill_bound, 1'b1, ring_fill <= FILL_W'(AVG_DEPTH), "fill count beyond ring depth")
	`PPSM_ASSERT_IMP(a_timeout_zero, m_tvalid && m_tuser[0], m_tdata == '0, "timeout result must carry zero speed")
	`PPSM_ASSERT_IMP(a_div_single_use, state_q == ST_RING || state_q == ST_MULG || state_q == ST_MUL, !div_stat.busy, "divider busy outside its phases")

endmodule

>>> design/ppsm_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on ppsm_pkg for the divisor width and the status struct.
`timescale 1ns / 1ps

module ppsm_div #(
	parameter int DVD_W = 25
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [DVD_W-1:0]          dividend,
	input  logic [ppsm_pkg::GAP_W-1:0] divisor,
	output logic [DVD_W-1:0]          quotient,
	output ppsm_pkg::op_stat_t        stat
);
	import ppsm_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [GAP_W-1:0] dsr_q;
	logic [GAP_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [GAP_W:0]   rem_sh;
	logic [GAP_W:0]   diff;
	logic             qbit;

	always_comb begin
		rem_sh = {rem_q, dvd_q[DVD_W-1]};
		diff   = rem_sh - {1'b0, dsr_q};
		qbit   = ~diff[GAP_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift in behind the dividend bits as they leave.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[GAP_W-1:0] : rem_sh[GAP_W-1:0];
		end
	end

	assign quotient  = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> design/ppsm_mul.sv
// Shift-add multiplier, one multiplier bit per cycle, with a preset accumulator.
// Depends on ppsm_pkg for operand widths and the status struct.
`timescale 1ns / 1ps

module ppsm_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ppsm_pkg::SUM_W-1:0]   mcand,
	input  logic [ppsm_pkg::SCALE_W-1:0] mplier,
	input  logic [ppsm_pkg::ACC_W-1:0]   acc_init,
	output logic [ppsm_pkg::ACC_W-1:0]   product,
	output ppsm_pkg::op_stat_t           stat
);
	import ppsm_pkg::*;

	localparam int CNT_W = $clog2(SCALE_W + 1);

	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   mcand_q;
	logic [SCALE_W-1:0] mplier_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(SCALE_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Add the shifted multiplicand where the current multiplier bit is set.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= acc_init;
			mcand_q  <= ACC_W'(mcand);
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[ACC_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[SCALE_W-1:1]};
		end
	end

	assign product   = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> design/ppsm_ring.sv
// Moving-average ring of rpm samples with running sum and fill count.
// Depends on ppsm_pkg for widths and the command struct.
`timescale 1ns / 1ps

module ppsm_ring #(
	parameter int AVG_DEPTH = 5
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ppsm_pkg::ring_cmd_t                   cmd,
	input  logic [ppsm_pkg::RPM_W-1:0]            rpm,
	output logic [ppsm_pkg::SUM_W-1:0]            sum,
	output logic [$clog2(AVG_DEPTH + 1)-1:0]      fill
);
	import ppsm_pkg::*;

	localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);

	logic [RPM_W-1:0]  ring_q [AVG_DEPTH];
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic [RPM_W-1:0]  old_rpm;

	assign old_rpm = ring_q[slot_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			slot_q <= '0;
			fill_q <= '0;
			sum_q  <= '0;
		end else if (cmd.push) begin
			// Replace the oldest sample and fold the change into the sum.
			ring_q[slot_q] <= rpm;
			sum_q          <= sum_q - SUM_W'(old_rpm) + SUM_W'(rpm);
			if (slot_q == SLOT_W'(AVG_DEPTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
			if (fill_q != FILL_W'(AVG_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign sum  = sum_q;
	assign fill = fill_q;

endmodule
